// ===== design/i2c_master_bit_engine_macros.svh =====
// ----------------------------------------------------------------------------
// i2c master bit engine assertion macros
// concurrent check helpers for the asserting design file
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2CMBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared widths, command codes and register indexes of the i2c bit engine
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int FuncW     = 3;
  localparam int ByteW     = 8;
  localparam int UnitW     = 16;
  localparam int PollW     = 8;
  localparam int DelayW    = 19;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  // commands
  localparam logic [FuncW-1:0] FUNC_NONE  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_START = 3'd1;
  localparam logic [FuncW-1:0] FUNC_STOP  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_WRITE = 3'd3;
  localparam logic [FuncW-1:0] FUNC_WAIT  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_READ  = 3'd5;
  localparam logic [FuncW-1:0] FUNC_ACK   = 3'd6;
  localparam logic [FuncW-1:0] FUNC_NACK  = 3'd7;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_UNIT_TICKS = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_POLL_LIMIT = 2'd1;

  localparam logic [UnitW-1:0] UNIT_TICKS_RESET = 16'd100;
  localparam logic [PollW-1:0] POLL_LIMIT_RESET = 8'd250;

  localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

// ===== design/i2cmbe_if.sv =====
// ----------------------------------------------------------------------------
// i2cmbe channel interfaces
// valid/ready channels for the tick items in and the line results out
// ----------------------------------------------------------------------------
interface i2cmbe_cmd_if
  import i2cmbe_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [ByteW-1:0] write_byte;
  logic             ack_after_read;
  logic             sda_level;

  modport source (output valid, func, write_byte, ack_after_read, sda_level, input ready);
  modport sink (input valid, func, write_byte, ack_after_read, sda_level, output ready);
endinterface

interface i2cmbe_res_if
  import i2cmbe_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_release;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] read_byte;
  logic             ack_missing;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, read_byte,
                  ack_missing, input ready);
  modport sink (input valid, scl_level, sda_release, busy_res, done_res, read_byte,
                ack_missing, output ready);
endinterface

// ===== design/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master line sequencer stepped once per accepted tick item
// ----------------------------------------------------------------------------
// Each item on cmd is one tick of the sequencer and gives exactly one result
// on res in the next cycle, from the result register. One item is taken every
// cycle unless res stalls: cmd.ready is high whenever the result register is
// empty or its item is being taken in the same cycle, so the sustained rate is
// one item per clock, set by the single state step between the state registers
// and the result register. A nonzero func is latched only while the sequencer
// is idle; delays count unit_ticks per microsecond unit and polls give up at
// poll_limit. Configuration writes take effect at the next tick.
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  i2cmbe_cmd_if.sink           cmd,
  i2cmbe_res_if.source         res
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_HI   = 4'd1;
  localparam logic [3:0] PH_ST_LO   = 4'd2;
  localparam logic [3:0] PH_SP_LO   = 4'd3;
  localparam logic [3:0] PH_SP_CK   = 4'd4;
  localparam logic [3:0] PH_SP_DA   = 4'd5;
  localparam logic [3:0] PH_WA_REL  = 4'd6;
  localparam logic [3:0] PH_WA_POLL = 4'd7;
  localparam logic [3:0] PH_AK_LO   = 4'd8;
  localparam logic [3:0] PH_AK_HI   = 4'd9;
  localparam logic [3:0] PH_WR_SET  = 4'd10;
  localparam logic [3:0] PH_WR_HI   = 4'd11;
  localparam logic [3:0] PH_WR_LO   = 4'd12;
  localparam logic [3:0] PH_RD_LO   = 4'd13;
  localparam logic [3:0] PH_RD_POLL = 4'd14;
  localparam logic [3:0] PH_RD_TAIL = 4'd15;

  logic [UnitW-1:0]  unit_ticks;
  logic [PollW-1:0]  poll_limit;

  logic [3:0]        phase, phase_next;
  logic [2:0]        bit_index, bit_index_next;
  logic [ByteW-1:0]  shift_byte, shift_byte_next;
  logic [DelayW-1:0] delay_count, delay_count_next;
  logic [PollW-1:0]  poll_count, poll_count_next;
  logic              scl_out, scl_out_next;
  logic              sda_out, sda_out_next;
  logic              ack_choice, ack_choice_next;
  logic              ack_timeout_flag, ack_timeout_flag_next;
  logic [ByteW-1:0]  rx_byte, rx_byte_next;
  logic              done_next;

  logic              do_enter;
  logic [3:0]        target;
  logic              rd_bit;

  logic [DelayW-1:0] hold1, hold2, hold4;
  logic              accept;

  assign hold1 = {3'b000, unit_ticks};
  assign hold2 = {2'b00, unit_ticks, 1'b0};
  assign hold4 = {1'b0, unit_ticks, 2'b00};

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
      poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_UNIT_TICKS: unit_ticks <= cfg_data;
        CFG_POLL_LIMIT: poll_limit <= cfg_data[PollW-1:0];
        default: ;
      endcase
    end
  end

  // one sequencer tick
  always_comb begin
    phase_next            = phase;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    delay_count_next      = delay_count;
    poll_count_next       = poll_count;
    scl_out_next          = scl_out;
    sda_out_next          = sda_out;
    ack_choice_next       = ack_choice;
    ack_timeout_flag_next = ack_timeout_flag;
    rx_byte_next          = rx_byte;
    done_next             = 1'b0;
    do_enter              = 1'b0;
    target                = PH_IDLE;
    rd_bit                = 1'b0;

    if (phase == PH_IDLE) begin
      do_enter = (cmd.func != FUNC_NONE);
      case (cmd.func)
        FUNC_START: target = PH_ST_HI;
        FUNC_STOP:  target = PH_SP_LO;
        FUNC_WRITE: begin
          shift_byte_next = cmd.write_byte;
          bit_index_next  = 3'd0;
          target          = PH_WR_SET;
        end
        FUNC_WAIT:  target = PH_WA_REL;
        FUNC_READ: begin
          ack_choice_next = cmd.ack_after_read;
          bit_index_next  = 3'd0;
          shift_byte_next = '0;
          target          = PH_RD_LO;
        end
        FUNC_ACK: begin
          ack_choice_next = 1'b1;
          target          = PH_AK_LO;
        end
        FUNC_NACK: begin
          ack_choice_next = 1'b0;
          target          = PH_AK_LO;
        end
        default: ;
      endcase
    end else if (phase == PH_WA_POLL) begin
      if (!cmd.sda_level) begin
        scl_out_next          = 1'b0;
        ack_timeout_flag_next = 1'b0;
        phase_next            = PH_IDLE;
        done_next             = 1'b1;
      end else if (poll_count >= poll_limit) begin
        // no acknowledge: flag it and run a stop
        ack_timeout_flag_next = 1'b1;
        do_enter              = 1'b1;
        target                = PH_SP_LO;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else if (phase == PH_RD_POLL) begin
      if (cmd.sda_level || (poll_count >= poll_limit)) begin
        rd_bit          = cmd.sda_level && (poll_count < poll_limit);
        shift_byte_next = {shift_byte[ByteW-2:0], rd_bit};
        if (bit_index == LAST_BIT) begin
          rx_byte_next = shift_byte_next;
        end
        do_enter = 1'b1;
        target   = PH_RD_TAIL;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else if (delay_count > 19'd1) begin
      delay_count_next = delay_count - 19'd1;
    end else begin
      do_enter = 1'b1;
      case (phase)
        PH_ST_HI:  target = PH_ST_LO;
        PH_ST_LO: begin
          scl_out_next = 1'b0;
          do_enter     = 1'b0;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
        end
        PH_SP_LO:  target = PH_SP_CK;
        PH_SP_CK:  target = PH_SP_DA;
        PH_SP_DA: begin
          do_enter   = 1'b0;
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end
        PH_WA_REL: target = PH_WA_POLL;
        PH_AK_LO:  target = PH_AK_HI;
        PH_AK_HI: begin
          scl_out_next = 1'b0;
          do_enter     = 1'b0;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
        end
        PH_WR_SET: target = PH_WR_HI;
        PH_WR_HI:  target = PH_WR_LO;
        PH_WR_LO: begin
          if (bit_index == LAST_BIT) begin
            do_enter   = 1'b0;
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end else begin
            bit_index_next = bit_index + 3'd1;
            target         = PH_WR_SET;
          end
        end
        PH_RD_LO:  target = PH_RD_POLL;
        PH_RD_TAIL: begin
          if (bit_index == LAST_BIT) begin
            target = PH_AK_LO;
          end else begin
            bit_index_next = bit_index + 3'd1;
            target         = PH_RD_LO;
          end
        end
        default: begin
          do_enter   = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end

    // line set-up on entry to a phase
    if (do_enter) begin
      phase_next = target;
      case (target)
        PH_ST_HI: begin
          scl_out_next     = 1'b1;
          sda_out_next     = 1'b1;
          delay_count_next = hold4;
        end
        PH_ST_LO: begin
          sda_out_next     = 1'b0;
          delay_count_next = hold4;
        end
        PH_SP_LO: begin
          scl_out_next     = 1'b0;
          sda_out_next     = 1'b0;
          delay_count_next = hold4;
        end
        PH_SP_CK: begin
          scl_out_next     = 1'b1;
          delay_count_next = hold2;
        end
        PH_SP_DA: begin
          sda_out_next     = 1'b1;
          delay_count_next = hold4;
        end
        PH_WA_REL: begin
          sda_out_next     = 1'b1;
          delay_count_next = hold1;
        end
        PH_WA_POLL: begin
          scl_out_next    = 1'b1;
          poll_count_next = '0;
        end
        PH_AK_LO: begin
          scl_out_next     = 1'b0;
          sda_out_next     = !ack_choice_next;
          delay_count_next = hold2;
        end
        PH_AK_HI: begin
          scl_out_next     = 1'b1;
          delay_count_next = hold2;
        end
        PH_WR_SET: begin
          scl_out_next     = 1'b0;
          sda_out_next     = shift_byte_next[ByteW-1];
          shift_byte_next  = {shift_byte_next[ByteW-2:0], 1'b0};
          delay_count_next = hold2;
        end
        PH_WR_HI: begin
          scl_out_next     = 1'b1;
          delay_count_next = hold2;
        end
        PH_WR_LO: begin
          scl_out_next     = 1'b0;
          delay_count_next = hold2;
        end
        PH_RD_LO: begin
          scl_out_next     = 1'b0;
          sda_out_next     = 1'b1;
          delay_count_next = hold2;
        end
        PH_RD_POLL: begin
          scl_out_next    = 1'b1;
          poll_count_next = '0;
        end
        PH_RD_TAIL: delay_count_next = hold1;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_index        <= 3'd0;
      shift_byte       <= '0;
      delay_count      <= '0;
      poll_count       <= '0;
      scl_out          <= 1'b1;
      sda_out          <= 1'b1;
      ack_choice       <= 1'b0;
      ack_timeout_flag <= 1'b0;
      rx_byte          <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      delay_count      <= delay_count_next;
      poll_count       <= poll_count_next;
      scl_out          <= scl_out_next;
      sda_out          <= sda_out_next;
      ack_choice       <= ack_choice_next;
      ack_timeout_flag <= ack_timeout_flag_next;
      rx_byte          <= rx_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl_level   <= scl_out_next;
      res.sda_release <= sda_out_next;
      res.busy_res    <= (phase_next != PH_IDLE);
      res.done_res    <= done_next;
      res.read_byte   <= rx_byte_next;
      res.ack_missing <= ack_timeout_flag_next;
    end
  end

  `I2CMBE_ASSERT_NOW(a_done_not_busy, clk, rst, res.valid && res.done_res, !res.busy_res,
                     "completion result still shows busy")
  `I2CMBE_ASSERT_NEXT(a_cmd_starts, clk, rst,
                      accept && (phase == PH_IDLE) && (cmd.func != FUNC_NONE),
                      (phase != PH_IDLE) && res.valid && res.busy_res,
                      "command taken while idle did not start a sequence")
  `I2CMBE_ASSERT_NOW(a_ready_when_empty, clk, rst, !res.valid, cmd.ready,
                     "input stalled with empty result register")
  `I2CMBE_ASSERT_NEXT(a_state_holds, clk, rst, !accept,
                      $stable(phase) && $stable(delay_count) && $stable(rx_byte),
                      "sequencer moved without an item")

endmodule

// ===== tb/sv/i2cmbe_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_tb_pkg
// line sequencer predictor and scoreboard for the i2c master bit engine bench
// ----------------------------------------------------------------------------
package i2cmbe_tb_pkg;
  import i2cmbe_pkg::*;

  typedef enum logic [4:0] {
    SEQ_IDLE,
    SEQ_START_HIGH,
    SEQ_START_LOW,
    SEQ_STOP_LOW,
    SEQ_STOP_CLOCK,
    SEQ_STOP_DATA,
    SEQ_ACKW_RELEASE,
    SEQ_ACKW_POLL,
    SEQ_ACK_LOW,
    SEQ_ACK_HIGH,
    SEQ_WR_SETUP,
    SEQ_WR_HIGH,
    SEQ_WR_LOW,
    SEQ_RD_LOW,
    SEQ_RD_POLL,
    SEQ_RD_TAIL
  } seq_phase_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] write_byte;
    logic             ack_after_read;
    logic             sda_level;
  } tick_item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_release;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
    logic             ack_missing;
  } line_state_t;

  class line_scoreboard;
    logic [UnitW-1:0]  unit_ticks;
    logic [PollW-1:0]  poll_limit;
    seq_phase_t        phase;
    logic [2:0]        bit_idx;
    logic [ByteW-1:0]  shreg;
    logic [DelayW-1:0] hold_left;
    logic [PollW-1:0]  polls;
    logic              scl;
    logic              sda;
    logic              ack_sel;
    logic              ack_miss;
    logic              done;
    logic [ByteW-1:0]  rx_byte;
    line_state_t       expected_lines[$];
    int                mismatch_count;
    int                tick_count;
    int                done_count;
    int                ack_timeouts;
    int                bytes_read;

    function new();
      unit_ticks     = UNIT_TICKS_RESET;
      poll_limit     = POLL_LIMIT_RESET;
      phase          = SEQ_IDLE;
      bit_idx        = '0;
      shreg          = '0;
      hold_left      = '0;
      polls          = '0;
      scl            = 1'b1;
      sda            = 1'b1;
      ack_sel        = 1'b0;
      ack_miss       = 1'b0;
      done           = 1'b0;
      rx_byte        = '0;
      mismatch_count = 0;
      tick_count     = 0;
      done_count     = 0;
      ack_timeouts   = 0;
      bytes_read     = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_UNIT_TICKS) unit_ticks = val[UnitW-1:0];
      else if (idx == CFG_POLL_LIMIT) poll_limit = val[PollW-1:0];
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void hold(int units);
      hold_left = DelayW'(units * int'(unit_ticks));
    endfunction

    function void finish_cmd();
      phase = SEQ_IDLE;
      done  = 1'b1;
      done_count++;
    endfunction

    function void enter(seq_phase_t ph);
      phase = ph;
      case (ph)
        SEQ_START_HIGH: begin
          scl = 1'b1; sda = 1'b1; hold(4);
        end
        SEQ_START_LOW: begin
          sda = 1'b0; hold(4);
        end
        SEQ_STOP_LOW: begin
          scl = 1'b0; sda = 1'b0; hold(4);
        end
        SEQ_STOP_CLOCK: begin
          scl = 1'b1; hold(2);
        end
        SEQ_STOP_DATA: begin
          sda = 1'b1; hold(4);
        end
        SEQ_ACKW_RELEASE: begin
          sda = 1'b1; hold(1);
        end
        SEQ_ACKW_POLL, SEQ_RD_POLL: begin
          scl = 1'b1; polls = '0;
        end
        SEQ_ACK_LOW: begin
          scl = 1'b0; sda = ~ack_sel; hold(2);
        end
        SEQ_ACK_HIGH, SEQ_WR_HIGH: begin
          scl = 1'b1; hold(2);
        end
        SEQ_WR_SETUP: begin
          scl   = 1'b0;
          sda   = shreg[7];
          shreg = {shreg[6:0], 1'b0};
          hold(2);
        end
        SEQ_WR_LOW: begin
          scl = 1'b0; hold(2);
        end
        SEQ_RD_LOW: begin
          scl = 1'b0; sda = 1'b1; hold(2);
        end
        SEQ_RD_TAIL: hold(1);
        default: phase = SEQ_IDLE;
      endcase
    endfunction

    function void take_bit(logic b);
      shreg = {shreg[6:0], b};
      if (bit_idx == LAST_BIT) begin
        rx_byte = shreg;
        bytes_read++;
      end
      enter(SEQ_RD_TAIL);
    endfunction

    function void advance();
      case (phase)
        SEQ_START_HIGH: enter(SEQ_START_LOW);
        SEQ_START_LOW: begin
          scl = 1'b0; finish_cmd();
        end
        SEQ_STOP_LOW:     enter(SEQ_STOP_CLOCK);
        SEQ_STOP_CLOCK:   enter(SEQ_STOP_DATA);
        SEQ_STOP_DATA:    finish_cmd();
        SEQ_ACKW_RELEASE: enter(SEQ_ACKW_POLL);
        SEQ_ACK_LOW:      enter(SEQ_ACK_HIGH);
        SEQ_ACK_HIGH: begin
          scl = 1'b0; finish_cmd();
        end
        SEQ_WR_SETUP: enter(SEQ_WR_HIGH);
        SEQ_WR_HIGH:  enter(SEQ_WR_LOW);
        SEQ_WR_LOW: begin
          if (bit_idx == LAST_BIT) finish_cmd();
          else begin
            bit_idx = bit_idx + 1'b1;
            enter(SEQ_WR_SETUP);
          end
        end
        SEQ_RD_LOW: enter(SEQ_RD_POLL);
        SEQ_RD_TAIL: begin
          if (bit_idx == LAST_BIT) enter(SEQ_ACK_LOW);
          else begin
            bit_idx = bit_idx + 1'b1;
            enter(SEQ_RD_LOW);
          end
        end
        default: phase = SEQ_IDLE;
      endcase
    endfunction

    // one tick of the line sequencer
    function void step_sequencer(tick_item_t t);
      done = 1'b0;
      if (phase == SEQ_IDLE) begin
        case (t.func)
          FUNC_START: enter(SEQ_START_HIGH);
          FUNC_STOP:  enter(SEQ_STOP_LOW);
          FUNC_WRITE: begin
            shreg = t.write_byte; bit_idx = '0; enter(SEQ_WR_SETUP);
          end
          FUNC_WAIT:  enter(SEQ_ACKW_RELEASE);
          FUNC_READ: begin
            ack_sel = t.ack_after_read; bit_idx = '0; shreg = '0; enter(SEQ_RD_LOW);
          end
          FUNC_ACK: begin
            ack_sel = 1'b1; enter(SEQ_ACK_LOW);
          end
          FUNC_NACK: begin
            ack_sel = 1'b0; enter(SEQ_ACK_LOW);
          end
          default: ;
        endcase
      end else if (phase == SEQ_ACKW_POLL) begin
        if (!t.sda_level) begin
          scl = 1'b0; ack_miss = 1'b0; finish_cmd();
        end else if (polls >= poll_limit) begin
          // no acknowledge: flag it and release the bus with a stop
          ack_miss = 1'b1;
          ack_timeouts++;
          enter(SEQ_STOP_LOW);
        end else polls = polls + 1'b1;
      end else if (phase == SEQ_RD_POLL) begin
        if (t.sda_level) take_bit(polls < poll_limit);
        else if (polls >= poll_limit) take_bit(1'b0);
        else polls = polls + 1'b1;
      end else if (hold_left > 1) hold_left = hold_left - 1'b1;
      else advance();
    endfunction

    function void note_tick(tick_item_t t);
      line_state_t want;
      step_sequencer(t);
      tick_count++;
      want.scl_level   = scl;
      want.sda_release = sda;
      want.busy_res    = (phase != SEQ_IDLE);
      want.done_res    = done;
      want.read_byte   = rx_byte;
      want.ack_missing = ack_miss;
      expected_lines.push_back(want);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got,
                                realtime stamp);
      if (want != got) begin
        mismatch_count++;
        $display("[%0.3f ns] %s mismatch: expected 0x%0h, actual 0x%0h",
                 stamp, field, want, got);
      end
    endfunction

    function void check_lines(line_state_t got, realtime stamp);
      line_state_t want;
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        $display("[%0.3f ns] unexpected result: expected none, actual 0x%0h", stamp, got);
        return;
      end
      want = expected_lines.pop_front();
      compare_field("scl_level", want.scl_level, got.scl_level, stamp);
      compare_field("sda_release", want.sda_release, got.sda_release, stamp);
      compare_field("busy_res", want.busy_res, got.busy_res, stamp);
      compare_field("done_res", want.done_res, got.done_res, stamp);
      compare_field("read_byte", want.read_byte, got.read_byte, stamp);
      compare_field("ack_missing", want.ack_missing, got.ack_missing, stamp);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// drives tick items into the i2c bit engine and checks every line result
// against a cycle-true predictor; directed corner cases first, then random
// i2c transactions with line noise under three idling modes
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbe_pkg::*;
  import i2cmbe_tb_pkg::*;

  localparam int CycleLimit = 4000000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  i2cmbe_cmd_if cmd_ch ();
  i2cmbe_res_if res_ch ();

  i2c_master_bit_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  line_scoreboard sb;
  tick_item_t     cur_item;
  tick_item_t     cmd_plan[$];
  int             forced_runs[$];
  int             wrong_left = -1;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             cycle_count = 0;
  int             settings_run = 0;
  line_state_t    seen_line;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check accepted items, stall at random
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else begin
      if (res_ch.valid && res_ch.ready) begin
        seen_line.scl_level   = res_ch.scl_level;
        seen_line.sda_release = res_ch.sda_release;
        seen_line.busy_res    = res_ch.busy_res;
        seen_line.done_res    = res_ch.done_res;
        seen_line.read_byte   = res_ch.read_byte;
        seen_line.ack_missing = res_ch.ack_missing;
        sb.check_lines(seen_line, $realtime);
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void add_cmd(logic [FuncW-1:0] f, logic [ByteW-1:0] b, logic aar);
    tick_item_t t;
    t.func           = f;
    t.write_byte     = b;
    t.ack_after_read = aar;
    t.sda_level      = 1'b0;
    cmd_plan.push_back(t);
  endfunction

  function automatic void plan_transaction();
    if ($urandom_range(4) == 0) begin
      // broken or odd sequence of arbitrary commands
      repeat ($urandom_range(1, 4))
        add_cmd(FuncW'($urandom_range(FUNC_START, FUNC_NACK)), ByteW'($urandom),
                1'($urandom));
    end else begin
      add_cmd(FUNC_START, ByteW'($urandom), 1'($urandom));
      add_cmd(FUNC_WRITE, ByteW'($urandom), 1'($urandom));
      add_cmd(FUNC_WAIT, ByteW'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(1) != 0) begin
          add_cmd(FUNC_WRITE, ByteW'($urandom), 1'($urandom));
          add_cmd(FUNC_WAIT, ByteW'($urandom), 1'($urandom));
        end else add_cmd(FUNC_READ, ByteW'($urandom), 1'($urandom));
      end
      add_cmd(FUNC_STOP, ByteW'($urandom), 1'($urandom));
    end
  endfunction

  // number of ticks sda stays at the wrong level in one poll
  function automatic int pick_wrong_run();
    int lim;
    lim = int'(sb.poll_limit);
    if (forced_runs.size() != 0) return forced_runs.pop_front();
    case ($urandom_range(7))
      0, 1, 2, 3: return $urandom_range(2);
      4: return lim;
      5: return lim + 1;
      default: return $urandom_range(lim + 1);
    endcase
  endfunction

  function automatic tick_item_t next_item();
    tick_item_t t;
    logic       wrong_level;
    t.func           = FUNC_NONE;
    t.write_byte     = ByteW'($urandom);
    t.ack_after_read = 1'($urandom);
    t.sda_level      = 1'($urandom);
    if (sb.phase == SEQ_IDLE) begin
      wrong_left = -1;
      if (cmd_plan.size() != 0 && $urandom_range(3) != 0) begin
        t           = cmd_plan.pop_front();
        t.sda_level = 1'($urandom);
      end
    end else begin
      // commands while busy are ignored by the block
      t.func = FuncW'($urandom);
      if (sb.phase == SEQ_ACKW_POLL || sb.phase == SEQ_RD_POLL) begin
        wrong_level = (sb.phase == SEQ_ACKW_POLL);
        if (wrong_left < 0) wrong_left = pick_wrong_run();
        if (wrong_left > 0) begin
          t.sda_level = wrong_level;
          wrong_left--;
        end else begin
          t.sda_level = ~wrong_level;
          wrong_left  = -1;
        end
      end else wrong_left = -1;
    end
    return t;
  endfunction

  // feed ticks until n_ticks are in, the plan is used up and the sequencer is idle
  task automatic drive_ticks(int n_ticks, bit refill);
    int sent;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    forever begin
      @(posedge clk);
      if (cmd_ch.valid && cmd_ch.ready) begin
        sb.note_tick(cur_item);
        sent++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (refill && sent >= n_ticks) cmd_plan.delete();
        if (sent >= n_ticks && sb.phase == SEQ_IDLE && cmd_plan.size() == 0) begin
          cmd_ch.valid <= 1'b0;
          break;
        end
        if (refill && !paused && sent >= n_ticks / 2) begin
          // hold off until every expected line state is back
          paused = 1'b1;
          cmd_ch.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end else if ($urandom_range(99) < send_idle_pct) cmd_ch.valid <= 1'b0;
        else begin
          if (refill && cmd_plan.size() == 0 && sb.phase == SEQ_IDLE) plan_transaction();
          cur_item = next_item();
          cmd_ch.func           <= cur_item.func;
          cmd_ch.write_byte     <= cur_item.write_byte;
          cmd_ch.ack_after_read <= cur_item.ack_after_read;
          cmd_ch.sda_level      <= cur_item.sda_level;
          cmd_ch.valid          <= 1'b1;
        end
      end
    end
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int unit, int lim);
    settle();
    write_reg(CFG_UNIT_TICKS, CfgDataW'(unit));
    write_reg(CFG_POLL_LIMIT, CfgDataW'(lim));
    settings_run++;
  endtask

  task automatic random_segment(int unit, int lim);
    configure(unit, lim);
    drive_ticks(150, 1'b1);
  endtask

  initial begin
    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_index             <= CFG_UNIT_TICKS;
    cfg_data              <= '0;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.func           <= FUNC_NONE;
    cmd_ch.write_byte     <= '0;
    cmd_ch.ack_after_read <= 1'b0;
    cmd_ch.sda_level      <= 1'b1;
    sb = new();
    send_idle_pct  = 31;
    recv_stall_pct = 79;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset register values: an acknowledge wait that times out
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(int'(POLL_LIMIT_RESET) + 1);
    drive_ticks(0, 1'b0);

    // short delays, small poll limit
    configure(1, 4);
    add_cmd(FUNC_WRITE, 8'h00, 1'b0);
    add_cmd(FUNC_WRITE, 8'hff, 1'b1);
    add_cmd(FUNC_WRITE, 8'ha5, 1'b0);
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(0);
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(4);
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(5);
    // read with ack: includes sda high exactly at the limit
    add_cmd(FUNC_READ, 8'h00, 1'b1);
    forced_runs.push_back(0); forced_runs.push_back(4); forced_runs.push_back(5);
    forced_runs.push_back(1); forced_runs.push_back(0); forced_runs.push_back(3);
    forced_runs.push_back(4); forced_runs.push_back(0);
    add_cmd(FUNC_READ, 8'hff, 1'b0);
    repeat (8) forced_runs.push_back(0);
    add_cmd(FUNC_ACK, 8'h00, 1'b0);
    add_cmd(FUNC_NACK, 8'h00, 1'b1);
    add_cmd(FUNC_STOP, 8'h00, 1'b0);
    add_cmd(FUNC_START, 8'h00, 1'b0);
    drive_ticks(0, 1'b0);

    // zero unit and zero poll limit
    configure(0, 0);
    add_cmd(FUNC_START, 8'h00, 1'b0);
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(0);
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(1);
    add_cmd(FUNC_READ, 8'h00, 1'b1);
    repeat (4) begin
      forced_runs.push_back(0);
      forced_runs.push_back(1);
    end
    add_cmd(FUNC_STOP, 8'h00, 1'b0);
    drive_ticks(0, 1'b0);

    // widest poll limit: acknowledge arrives on the last allowed poll
    configure(1, 255);
    add_cmd(FUNC_WAIT, 8'h00, 1'b0);
    forced_runs.push_back(255);
    drive_ticks(0, 1'b0);

    random_segment(1, 3);
    random_segment(3, 255);
    send_idle_pct  = 79;
    recv_stall_pct = 31;
    random_segment(2, 0);
    random_segment(1, 1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_segment(4, 6);
    random_segment(1, 2);

    settle();
    repeat (8) @(posedge clk);
    $display("ran %0d ticks over %0d register settings: %0d commands completed,",
             sb.tick_count, settings_run, sb.done_count);
    $display("%0d acknowledge timeouts, %0d bytes read", sb.ack_timeouts, sb.bytes_read);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d line states never seen", sb.mismatch_count,
               sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
